// ----- rtl/yuvt_pkg.sv -----
// shared types and constants for the yuyv to tiled yuv 4:2:0 address generator
// used by every module of the block; depends on nothing else
package yuvt_pkg;

  // configuration port
  localparam int CFG_DATA_W  = 13;
  localparam int CFG_INDEX_W = 1;
  localparam logic [CFG_INDEX_W-1:0] REG_FRAME_WIDTH  = 1'b0;
  localparam logic [CFG_INDEX_W-1:0] REG_FRAME_HEIGHT = 1'b1;
  localparam logic [CFG_DATA_W-1:0]  FRAME_DIM_RESET  = 13'd16;

  // default frame limits
  localparam int DEFAULT_MAX_WIDTH  = 4096;
  localparam int DEFAULT_MAX_HEIGHT = 4096;

  // field widths
  localparam int PIXEL_PAIR_W  = 32;
  localparam int LUMA_ADDR_W   = 24;
  localparam int LUMA_PAIR_W   = 16;
  localparam int CHROMA_ADDR_W = 23;
  localparam int CHROMA_W      = 8;
  // macroblock index bits that reach the luma address (256 bytes per macroblock)
  localparam int MB_ADDR_W     = LUMA_ADDR_W - 8;

  // stream widths
  localparam int IN_TDATA_W  = 32;
  localparam int OUT_TDATA_W = 80;
  localparam int OUT_TUSER_W = 1;

  // queue between front and back
  localparam int QUEUE_DEPTH = 2;

  // one classified word on its way from front to back
  typedef struct packed {
    logic [MB_ADDR_W-1:0]    mb_addr;
    logic [3:0]              row_lo;
    logic [2:0]              col_lo;
    logic [PIXEL_PAIR_W-1:0] pixel_pair;
    logic                    in_picture;
    logic                    even;
    logic                    frame_end;
  } yuvt_item_t;

  // queue status seen by the front and back
  typedef struct packed {
    logic full;
    logic empty;
  } yuvt_queue_status_t;

endpackage

// ----- rtl/yuvt_front.sv -----
// front part: configuration registers, raster position counters and classification
// depends on yuvt_pkg
module yuvt_front #(
  parameter int MAX_WIDTH  = yuvt_pkg::DEFAULT_MAX_WIDTH,
  parameter int MAX_HEIGHT = yuvt_pkg::DEFAULT_MAX_HEIGHT
) (
  input  logic                               clk,
  input  logic                               rst,
  input  logic                               cfg_we,
  input  logic [yuvt_pkg::CFG_INDEX_W-1:0]   cfg_index,
  input  logic [yuvt_pkg::CFG_DATA_W-1:0]    cfg_data,
  input  logic                               in_valid,
  output logic                               in_ready,
  input  logic [yuvt_pkg::PIXEL_PAIR_W-1:0]  in_data,
  input  yuvt_pkg::yuvt_queue_status_t       queue_status,
  output logic                               push,
  output yuvt_pkg::yuvt_item_t               item
);

  localparam int PW_W  = $clog2(MAX_WIDTH + 16);
  localparam int PH_W  = $clog2(MAX_HEIGHT + 16);
  localparam int COL_W = PW_W - 1;
  localparam int MBR_W = PW_W - 4;
  localparam int MB_W  = PW_W + PH_W - 8;

  logic [yuvt_pkg::CFG_DATA_W-1:0] frame_width;
  logic [yuvt_pkg::CFG_DATA_W-1:0] frame_height;
  logic [COL_W-1:0]                pair_column;
  logic [PH_W-1:0]                 row_index;
  logic [MB_W-1:0]                 mb_base;

  logic [PW_W-1:0]  width_eff;
  logic [PH_W-1:0]  height_eff;
  logic [PW_W-1:0]  width_sum;
  logic [PH_W-1:0]  height_sum;
  logic [PW_W-1:0]  width_pad;
  logic [PH_W-1:0]  height_pad;
  logic [COL_W-1:0] last_col;
  logic [PH_W-1:0]  last_row;
  logic [MBR_W-1:0] mb_per_row;
  logic             col_at_end;
  logic             row_at_end;
  logic [MB_W-1:0]  mb;

  // clamp the picture size into the supported range
  always_comb begin
    if (frame_width == '0) begin
      width_eff = PW_W'(1);
    end else if (32'(frame_width) > 32'(MAX_WIDTH)) begin
      width_eff = PW_W'(MAX_WIDTH);
    end else begin
      width_eff = PW_W'(frame_width);
    end
    if (frame_height == '0) begin
      height_eff = PH_W'(1);
    end else if (32'(frame_height) > 32'(MAX_HEIGHT)) begin
      height_eff = PH_W'(MAX_HEIGHT);
    end else begin
      height_eff = PH_W'(frame_height);
    end
  end

  // pad to whole macroblocks
  assign width_sum  = width_eff + PW_W'(15);
  assign height_sum = height_eff + PH_W'(15);
  assign width_pad  = {width_sum[PW_W-1:4], 4'b0000};
  assign height_pad = {height_sum[PH_W-1:4], 4'b0000};
  assign last_col   = width_pad[PW_W-1:1] - COL_W'(1);
  assign last_row   = height_pad - PH_W'(1);
  assign mb_per_row = width_pad[PW_W-1:4];

  assign col_at_end = (pair_column == last_col);
  assign row_at_end = (row_index == last_row);
  assign mb         = mb_base + MB_W'(pair_column[COL_W-1:3]);

  // classify the current word
  assign in_ready = !queue_status.full;
  assign push     = in_valid && in_ready;

  always_comb begin
    item            = '0;
    item.mb_addr    = yuvt_pkg::MB_ADDR_W'(mb);
    item.row_lo     = row_index[3:0];
    item.col_lo     = pair_column[2:0];
    item.pixel_pair = in_data;
    item.in_picture = (row_index < height_eff) && ({pair_column, 1'b0} < width_eff);
    item.even       = !row_index[0];
    item.frame_end  = col_at_end && row_at_end;
  end

  // configuration and position counters
  always_ff @(posedge clk) begin
    if (rst) begin
      frame_width  <= yuvt_pkg::FRAME_DIM_RESET;
      frame_height <= yuvt_pkg::FRAME_DIM_RESET;
      pair_column  <= '0;
      row_index    <= '0;
      mb_base      <= '0;
    end else if (cfg_we) begin
      case (cfg_index)
        yuvt_pkg::REG_FRAME_WIDTH:  frame_width  <= cfg_data;
        yuvt_pkg::REG_FRAME_HEIGHT: frame_height <= cfg_data;
        default: ;
      endcase
      pair_column <= '0;
      row_index   <= '0;
      mb_base     <= '0;
    end else if (push) begin
      if (col_at_end) begin
        pair_column <= '0;
        if (row_at_end) begin
          row_index <= '0;
          mb_base   <= '0;
        end else begin
          row_index <= row_index + PH_W'(1);
          // next macroblock row starts after the last row of this one
          if (row_index[3:0] == 4'hF) begin
            mb_base <= mb_base + MB_W'(mb_per_row);
          end
        end
      end else begin
        pair_column <= pair_column + COL_W'(1);
      end
    end
  end

endmodule

// ----- rtl/yuvt_queue.sv -----
// short queue between the front and back parts
// depends on yuvt_pkg
module yuvt_queue (
  input  logic                         clk,
  input  logic                         rst,
  input  logic                         push,
  input  yuvt_pkg::yuvt_item_t         push_item,
  input  logic                         pop,
  output yuvt_pkg::yuvt_item_t         head_item,
  output yuvt_pkg::yuvt_queue_status_t status
);

  localparam int DEPTH = yuvt_pkg::QUEUE_DEPTH;
  localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CNT_W = $clog2(DEPTH + 1);

  yuvt_pkg::yuvt_item_t entries [DEPTH];
  logic [PTR_W-1:0] wr_ptr;
  logic [PTR_W-1:0] rd_ptr;
  logic [CNT_W-1:0] count;
  logic             do_push;
  logic             do_pop;

  assign status.full  = (count == CNT_W'(DEPTH));
  assign status.empty = (count == '0);
  assign do_push      = push && !status.full;
  assign do_pop       = pop && !status.empty;
  assign head_item    = entries[rd_ptr];

  // storage
  always_ff @(posedge clk) begin
    if (do_push) begin
      entries[wr_ptr] <= push_item;
    end
  end

  // pointers and fill level
  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (do_push) begin
        wr_ptr <= (wr_ptr == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr + PTR_W'(1);
      end
      if (do_pop) begin
        rd_ptr <= (rd_ptr == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr + PTR_W'(1);
      end
      if (do_push && !do_pop) begin
        count <= count + CNT_W'(1);
      end else if (do_pop && !do_push) begin
        count <= count - CNT_W'(1);
      end
    end
  end

endmodule

// ----- rtl/yuvt_back.sv -----
// back part: forms tiled addresses, masks data outside the picture, holds the result
// depends on yuvt_pkg
module yuvt_back (
  input  logic                                clk,
  input  logic                                rst,
  input  yuvt_pkg::yuvt_item_t                head_item,
  input  yuvt_pkg::yuvt_queue_status_t        queue_status,
  output logic                                pop,
  output logic                                out_valid,
  input  logic                                out_ready,
  output logic [yuvt_pkg::OUT_TDATA_W-1:0]    out_data,
  output logic [yuvt_pkg::OUT_TUSER_W-1:0]    out_user,
  output logic                                out_last
);

  logic [yuvt_pkg::LUMA_ADDR_W-1:0]   luma_addr;
  logic [yuvt_pkg::LUMA_PAIR_W-1:0]   luma_pair;
  logic                               chroma_valid;
  logic [yuvt_pkg::CHROMA_ADDR_W-1:0] chroma_addr;
  logic [yuvt_pkg::CHROMA_W-1:0]      chroma_a;
  logic [yuvt_pkg::CHROMA_W-1:0]      chroma_b;
  logic                               chroma_on;

  // luma: 256-byte macroblock, 16-byte rows, two bytes per pair
  assign luma_addr = {head_item.mb_addr, head_item.row_lo, head_item.col_lo, 1'b0};
  assign luma_pair = head_item.in_picture ?
                     {head_item.pixel_pair[23:16], head_item.pixel_pair[7:0]} : '0;

  // chroma: 128-byte block, 16 bytes per even row, b sits eight bytes after a
  assign chroma_valid = head_item.even;
  assign chroma_on    = head_item.even && head_item.in_picture;
  assign chroma_addr  = head_item.even ?
                        {head_item.mb_addr, head_item.row_lo[3:1], 1'b0, head_item.col_lo} :
                        '0;
  assign chroma_a = chroma_on ? head_item.pixel_pair[15:8]  : '0;
  assign chroma_b = chroma_on ? head_item.pixel_pair[31:24] : '0;

  // take the next item whenever the output register is free or being emptied
  assign pop = !queue_status.empty && (!out_valid || out_ready);

  // output register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (pop) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (pop) begin
      out_data <= yuvt_pkg::OUT_TDATA_W'({chroma_b, chroma_a, chroma_addr,
                                          luma_pair, luma_addr});
      out_user <= yuvt_pkg::OUT_TUSER_W'(chroma_valid);
      out_last <= head_item.frame_end;
    end
  end

endmodule

// ----- rtl/yuyv_to_yuv420_mcu_tiler_unit.sv -----
// top level of the yuyv to tiled yuv 4:2:0 address generator
// depends on yuvt_pkg, yuvt_front, yuvt_queue and yuvt_back
//
// channel    direction  ports                        contents
// s_axis     in         tvalid tready tdata[31:0]    one yuyv word (two pixels)
// m_axis     out        tvalid tready tdata tuser    tiled addresses and data
//                       tlast                        of one word
// cfg        in         cfg_we cfg_index cfg_data    frame_width, frame_height
//
// one word per clock is accepted and one result per clock leaves while m_axis does not
// stall; a result goes from s_axis into a queue entry and from there into the output
// register, which drives m_axis
// reset: position counters cleared, frame_width and frame_height set to 16
// a stall on m_axis fills the two-entry queue; s_axis tready falls only when it is full
// any configuration write restarts the frame at the top-left word
module yuyv_to_yuv420_mcu_tiler_unit #(
  parameter int MAX_WIDTH  = yuvt_pkg::DEFAULT_MAX_WIDTH,
  parameter int MAX_HEIGHT = yuvt_pkg::DEFAULT_MAX_HEIGHT
) (
  input  logic                              clk,
  input  logic                              rst,
  // configuration writes
  input  logic                              cfg_we,
  input  logic [yuvt_pkg::CFG_INDEX_W-1:0]  cfg_index,
  input  logic [yuvt_pkg::CFG_DATA_W-1:0]   cfg_data,
  // input stream
  input  logic                              s_axis_tvalid,
  output logic                              s_axis_tready,
  // [31:0] pixel_pair
  input  logic [yuvt_pkg::IN_TDATA_W-1:0]   s_axis_tdata,
  // output stream
  output logic                              m_axis_tvalid,
  input  logic                              m_axis_tready,
  // [23:0] luma_addr, [39:24] luma_pair, [62:40] chroma_addr,
  // [70:63] chroma_a, [78:71] chroma_b, [79] zero
  output logic [yuvt_pkg::OUT_TDATA_W-1:0]  m_axis_tdata,
  // [0] chroma_valid
  output logic [yuvt_pkg::OUT_TUSER_W-1:0]  m_axis_tuser,
  // frame_end
  output logic                              m_axis_tlast
);

  yuvt_pkg::yuvt_item_t         push_item;
  yuvt_pkg::yuvt_item_t         head_item;
  yuvt_pkg::yuvt_queue_status_t queue_status;
  logic                         push;
  logic                         pop;

  // front: counters and classification
  yuvt_front #(
    .MAX_WIDTH  (MAX_WIDTH),
    .MAX_HEIGHT (MAX_HEIGHT)
  ) u_front (
    .clk          (clk),
    .rst          (rst),
    .cfg_we       (cfg_we),
    .cfg_index    (cfg_index),
    .cfg_data     (cfg_data),
    .in_valid     (s_axis_tvalid),
    .in_ready     (s_axis_tready),
    .in_data      (s_axis_tdata[yuvt_pkg::PIXEL_PAIR_W-1:0]),
    .queue_status (queue_status),
    .push         (push),
    .item         (push_item)
  );

  // decoupling queue
  yuvt_queue u_queue (
    .clk       (clk),
    .rst       (rst),
    .push      (push),
    .push_item (push_item),
    .pop       (pop),
    .head_item (head_item),
    .status    (queue_status)
  );

  // back: address forming and output register
  yuvt_back u_back (
    .clk          (clk),
    .rst          (rst),
    .head_item    (head_item),
    .queue_status (queue_status),
    .pop          (pop),
    .out_valid    (m_axis_tvalid),
    .out_ready    (m_axis_tready),
    .out_data     (m_axis_tdata),
    .out_user     (m_axis_tuser),
    .out_last     (m_axis_tlast)
  );

endmodule

// ----- sim/testbench.sv -----
// self-checking testbench for yuyv_to_yuv420_mcu_tiler_unit: streams yuyv words,
// predicts tiled luma/chroma addresses and data, compares every output transaction
// depends on rtl/yuvt_pkg.sv and rtl/yuyv_to_yuv420_mcu_tiler_unit.sv
module testbench;
  import yuvt_pkg::*;

  localparam int MAX_W = DEFAULT_MAX_WIDTH;
  localparam int MAX_H = DEFAULT_MAX_HEIGHT;

  // one expected output transaction
  typedef struct packed {
    logic [LUMA_ADDR_W-1:0]   luma_addr;
    logic [LUMA_PAIR_W-1:0]   luma_pair;
    logic                     chroma_valid;
    logic [CHROMA_ADDR_W-1:0] chroma_addr;
    logic [CHROMA_W-1:0]      chroma_a;
    logic [CHROMA_W-1:0]      chroma_b;
    logic                     frame_end;
  } tile_result_t;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic cfg_we = 1'b0;
  logic [CFG_INDEX_W-1:0] cfg_index = REG_FRAME_WIDTH;
  logic [CFG_DATA_W-1:0] cfg_data = '0;
  logic s_axis_tvalid = 1'b0;
  logic s_axis_tready;
  logic [IN_TDATA_W-1:0] s_axis_tdata = '0;
  logic m_axis_tvalid;
  logic m_axis_tready = 1'b0;
  logic [OUT_TDATA_W-1:0] m_axis_tdata;
  logic [OUT_TUSER_W-1:0] m_axis_tuser;
  logic m_axis_tlast;

  // predictor state: raw registers and the position in the padded frame
  logic [CFG_DATA_W-1:0] frame_w_reg = FRAME_DIM_RESET;
  logic [CFG_DATA_W-1:0] frame_h_reg = FRAME_DIM_RESET;
  int unsigned pair_col = 0;
  int unsigned row_pos = 0;

  tile_result_t pending_tiles[$];

  int unsigned send_idle_pct = 0;
  int unsigned recv_idle_pct = 0;
  int unsigned hold_left = 0;
  int unsigned words_sent = 0;
  int unsigned results_checked = 0;
  int unsigned frame_ends_seen = 0;
  int unsigned settings_used = 0;
  int unsigned mismatches = 0;

  yuyv_to_yuv420_mcu_tiler_unit #(
    .MAX_WIDTH (MAX_W),
    .MAX_HEIGHT(MAX_H)
  ) dut (
    .clk          (clk),
    .rst          (rst),
    .cfg_we       (cfg_we),
    .cfg_index    (cfg_index),
    .cfg_data     (cfg_data),
    .s_axis_tvalid(s_axis_tvalid),
    .s_axis_tready(s_axis_tready),
    .s_axis_tdata (s_axis_tdata),
    .m_axis_tvalid(m_axis_tvalid),
    .m_axis_tready(m_axis_tready),
    .m_axis_tdata (m_axis_tdata),
    .m_axis_tuser (m_axis_tuser),
    .m_axis_tlast (m_axis_tlast)
  );

  always #1 clk = ~clk;

  // watchdog
  initial begin
    #4000000;
    $display("timeout: %0d results still pending", pending_tiles.size());
    $display("Testbench completed WITH ERRORS");
    $finish;
  end

  // zero counts as one, anything above the limit counts as the limit
  function automatic int unsigned clamp_dim(input logic [CFG_DATA_W-1:0] v,
                                            input int unsigned lim);
    if (v == 0) return 1;
    if (v > lim) return lim;
    return 32'(v);
  endfunction

  // tiled addresses and data for one word, then step the frame position
  function automatic tile_result_t next_tile_result(input logic [31:0] word);
    int unsigned w, h, pw, ph, pairs, mb_per_row, col, row, mb;
    bit in_pic, even;
    tile_result_t r;
    w = clamp_dim(frame_w_reg, MAX_W);
    h = clamp_dim(frame_h_reg, MAX_H);
    pw = (w + 15) & ~32'd15;
    ph = (h + 15) & ~32'd15;
    pairs = pw >> 1;
    mb_per_row = pw >> 4;
    col = (pair_col >= pairs) ? 0 : pair_col;
    row = (row_pos >= ph) ? 0 : row_pos;
    in_pic = (row < h) && ((col << 1) < w);
    even = (row & 1) == 0;
    mb = (row >> 4) * mb_per_row + (col >> 3);
    r.luma_addr = LUMA_ADDR_W'(mb * 256 + (row & 15) * 16 + (col & 7) * 2);
    r.luma_pair = in_pic ? {word[23:16], word[7:0]} : '0;
    r.chroma_valid = even;
    r.chroma_addr = even ?
                    CHROMA_ADDR_W'(mb * 128 + ((row & 15) >> 1) * 16 + (col & 7)) : '0;
    r.chroma_a = (even && in_pic) ? word[15:8] : '0;
    r.chroma_b = (even && in_pic) ? word[31:24] : '0;
    r.frame_end = (row == ph - 1) && (col == pairs - 1);
    col++;
    if (col >= pairs) begin
      col = 0;
      row++;
      if (row >= ph) row = 0;
    end
    pair_col = col;
    row_pos = row;
    return r;
  endfunction

  // one word on s_axis; starts and ends just after a falling edge
  task automatic send_word(input logic [31:0] word);
    while ($urandom_range(99) < send_idle_pct) begin
      s_axis_tvalid <= 1'b0;
      @(negedge clk);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tdata <= word;
    do @(posedge clk); while (!s_axis_tready);
    pending_tiles.push_back(next_tile_result(word));
    words_sent++;
    @(negedge clk);
  endtask

  // drop tvalid and wait for every expected result, then let the pipe empty
  task automatic wait_drained();
    s_axis_tvalid <= 1'b0;
    @(negedge clk);
    while (pending_tiles.size() != 0) @(negedge clk);
    repeat (4) @(negedge clk);
  endtask

  // register write, only called with the block idle
  task automatic cfg_write(input logic [CFG_INDEX_W-1:0] idx,
                           input logic [CFG_DATA_W-1:0] val);
    cfg_we <= 1'b1;
    cfg_index <= idx;
    cfg_data <= val;
    @(negedge clk);
    cfg_we <= 1'b0;
    @(negedge clk);
    if (idx == REG_FRAME_WIDTH) frame_w_reg = val;
    else frame_h_reg = val;
    pair_col = 0;
    row_pos = 0;
  endtask

  task automatic set_frame(input logic [CFG_DATA_W-1:0] w, input logic [CFG_DATA_W-1:0] h);
    wait_drained();
    cfg_write(REG_FRAME_WIDTH, w);
    cfg_write(REG_FRAME_HEIGHT, h);
    settings_used++;
  endtask

  // receiver: random stalls, or a long hold when one is requested
  initial begin
    forever begin
      @(negedge clk);
      if (hold_left != 0) begin
        m_axis_tready <= 1'b0;
        hold_left = hold_left - 1;
      end else begin
        m_axis_tready <= ($urandom_range(99) >= recv_idle_pct);
      end
    end
  end

  task automatic flag_mismatch(input string what, input logic [31:0] want,
                               input logic [31:0] got);
    if (mismatches < 10)
      $display("mismatch in %s at result %0d: expected 0x%0h, got 0x%0h",
               what, results_checked, want, got);
    mismatches++;
  endtask

  // compare every output transaction with the oldest expectation
  always @(posedge clk) begin
    tile_result_t want;
    tile_result_t got;
    if (!rst && m_axis_tvalid && m_axis_tready) begin
      got.luma_addr    = m_axis_tdata[23:0];
      got.luma_pair    = m_axis_tdata[39:24];
      got.chroma_addr  = m_axis_tdata[62:40];
      got.chroma_a     = m_axis_tdata[70:63];
      got.chroma_b     = m_axis_tdata[78:71];
      got.chroma_valid = m_axis_tuser[0];
      got.frame_end    = m_axis_tlast;
      if (pending_tiles.size() == 0) begin
        flag_mismatch("unexpected result", 0, 32'(got.luma_addr));
      end else begin
        want = pending_tiles.pop_front();
        if (got.luma_addr != want.luma_addr)
          flag_mismatch("luma_addr", 32'(want.luma_addr), 32'(got.luma_addr));
        if (got.luma_pair != want.luma_pair)
          flag_mismatch("luma_pair", 32'(want.luma_pair), 32'(got.luma_pair));
        if (got.chroma_valid != want.chroma_valid)
          flag_mismatch("chroma_valid", 32'(want.chroma_valid), 32'(got.chroma_valid));
        if (got.chroma_addr != want.chroma_addr)
          flag_mismatch("chroma_addr", 32'(want.chroma_addr), 32'(got.chroma_addr));
        if (got.chroma_a != want.chroma_a)
          flag_mismatch("chroma_a", 32'(want.chroma_a), 32'(got.chroma_a));
        if (got.chroma_b != want.chroma_b)
          flag_mismatch("chroma_b", 32'(want.chroma_b), 32'(got.chroma_b));
        if (got.frame_end != want.frame_end)
          flag_mismatch("frame_end", 32'(want.frame_end), 32'(got.frame_end));
        if (m_axis_tdata[79] != 1'b0)
          flag_mismatch("tdata pad bit", 0, 32'(m_axis_tdata[79]));
      end
      if (got.frame_end) frame_ends_seen++;
      results_checked++;
    end
  end

  // reset frame size: data extremes across an even row and into the odd row
  task automatic test_default_frame();
    logic [31:0] patterns[6];
    patterns = '{32'h0000_0000, 32'hFFFF_FFFF, 32'h00FF_00FF, 32'hFF00_FF00,
                 32'hA5A5_5A5A, 32'h0102_0304};
    settings_used++;
    foreach (patterns[i]) send_word(patterns[i]);
    repeat (4) send_word($urandom);
  endtask

  // odd width: pair straddling the right edge is kept whole, the rest is zeroed
  task automatic test_odd_width_edge();
    set_frame(13'd3, 13'd1);
    repeat (10) send_word($urandom);
  endtask

  // zero and oversized register values; a write mid-row restarts the frame
  task automatic test_clamped_dims();
    set_frame(13'd0, 13'd8191);
    repeat (3) send_word($urandom);
    wait_drained();
    cfg_write(REG_FRAME_WIDTH, 13'd8191);
    cfg_write(REG_FRAME_HEIGHT, 13'd0);
    settings_used++;
    repeat (2) send_word($urandom);
  endtask

  function automatic logic [CFG_DATA_W-1:0] pick_dim();
    int unsigned r;
    r = $urandom_range(99);
    if (r < 70) return CFG_DATA_W'($urandom_range(16, 1));
    if (r < 85) return CFG_DATA_W'($urandom_range(48, 17));
    case ($urandom_range(4))
      0: return 13'd0;
      1: return 13'd4096;
      2: return 13'd8191;
      3: return 13'd4095;
      default: return CFG_DATA_W'($urandom_range(8191));
    endcase
  endfunction

  // random frame settings, each followed by a random run of words
  task automatic test_random_frames(input int unsigned budget, input int unsigned send_pct,
                                    input int unsigned recv_pct);
    int unsigned start_count;
    int unsigned run_len;
    int unsigned which;
    send_idle_pct = send_pct;
    recv_idle_pct = recv_pct;
    start_count = words_sent;
    while (words_sent - start_count < budget) begin
      which = $urandom_range(2);
      if (which == 0) begin
        set_frame(pick_dim(), pick_dim());
      end else begin
        wait_drained();
        cfg_write(which == 1 ? REG_FRAME_WIDTH : REG_FRAME_HEIGHT, pick_dim());
        settings_used++;
      end
      run_len = $urandom_range(300, 20);
      // keep the total close to the budget
      if (run_len > budget - (words_sent - start_count))
        run_len = budget - (words_sent - start_count);
      repeat (run_len) send_word($urandom);
    end
  endtask

  // long receiver hold while words keep coming, then a second hold while the sender idles at random
  task automatic test_backpressure();
    send_idle_pct = 0;
    recv_idle_pct = 22;
    set_frame(13'd16, 13'd16);
    @(posedge clk);
    hold_left = 200;
    @(negedge clk);
    repeat (80) send_word($urandom);
    wait_drained();
    repeat (60) send_word($urandom);
    send_idle_pct = 50;
    s_axis_tvalid <= 1'b0;
    @(posedge clk);
    hold_left = 150;
    @(negedge clk);
    repeat (40) send_word($urandom);
  endtask

  initial begin
    repeat (11) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;
    @(negedge clk);
    send_idle_pct = 22;
    recv_idle_pct = 75;
    test_default_frame();
    test_odd_width_edge();
    test_clamped_dims();
    test_random_frames(600, 22, 75);
    test_random_frames(600, 75, 22);
    test_backpressure();
    test_random_frames(550, 0, 0);
    wait_drained();
    repeat (10) @(negedge clk);
    $display("run covered %0d words over %0d frame settings, %0d results checked,",
             words_sent, settings_used, results_checked);
    $display("%0d frame ends seen, %0d mismatches", frame_ends_seen, mismatches);
    if (mismatches == 0 && pending_tiles.size() == 0) begin
      $display("Testbench completed without errors");
    end else begin
      $display("Testbench completed WITH ERRORS");
    end
    $finish;
  end

endmodule
